// File: hw/rtl/boel_pkg.sv
// boel_pkg: shared sizes, command codes and the memory request struct of the
// ordered list engine. No dependencies.
`default_nettype none

package boel_pkg;

	// list capacity and derived widths
	localparam int CAPACITY = 64;
	localparam int DW       = 32;
	localparam int POS_W    = 6;
	localparam int CNT_OW   = 7;
	localparam int AW       = $clog2(CAPACITY);
	localparam int CW       = $clog2(CAPACITY + 1);
	localparam int CMPW     = (CW > POS_W) ? CW : POS_W;

	// command codes
	typedef enum logic [2:0] {
		CMD_INS_HEAD = 3'd0,
		CMD_INS_TAIL = 3'd1,
		CMD_INS_POS  = 3'd2,
		CMD_REM_HEAD = 3'd3,
		CMD_REM_TAIL = 3'd4,
		CMD_REM_POS  = 3'd5,
		CMD_SEARCH   = 3'd6,
		CMD_CLEAR    = 3'd7
	} cmd_t;

	// one cycle of traffic to the entry memory
	typedef struct packed {
		logic          rd_en;
		logic [AW-1:0] rd_addr;
		logic          wr_en;
		logic [AW-1:0] wr_addr;
		logic [DW-1:0] wr_data;
	} mem_req_t;

endpackage

`default_nettype wire

// File: hw/rtl/boel_if.sv
// boel_if: valid/ready channel interfaces for command requests and results.
// Uses field widths from boel_pkg.
`default_nettype none

interface boel_req_if;
	logic                          valid;
	logic                          ready;
	logic [2:0]                    cmd;
	logic signed [boel_pkg::DW-1:0] item_value;
	logic [boel_pkg::POS_W-1:0]    position;

	modport source (output valid, output cmd, output item_value, output position, input ready);
	modport sink   (input valid, input cmd, input item_value, input position, output ready);
endinterface

interface boel_rsp_if;
	logic                            valid;
	logic                            ready;
	logic                            status;
	logic                            found;
	logic signed [boel_pkg::DW-1:0]  found_value;
	logic [boel_pkg::CNT_OW-1:0]     entry_count;
	logic                            is_empty;

	modport source (output valid, output status, output found, output found_value,
		output entry_count, output is_empty, input ready);
	modport sink   (input valid, input status, input found, input found_value,
		input entry_count, input is_empty, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bounded_ordered_list_engine_core.sv
// Ordered list engine: up to CAPACITY signed 32-bit values kept dense in one ram.
// A search reads every entry, a positional insert moves the entries from the position
// up and a positional remove moves those above it; an untaken result holds the engine.
// One request at a time, set by the single ram read port walking the list. Reset
// clears the count and channel state; the ram is not cleared (entries above the count are never read).
`default_nettype none

module bounded_ordered_list_engine_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	boel_req_if.sink   req,
	boel_rsp_if.source rsp
);

	boel_pkg::mem_req_t       mem_req;
	logic [boel_pkg::DW-1:0]  mem_rdata;

	// sequencer
	boel_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	// entry store
	boel_ram #(
		.WIDTH (boel_pkg::DW),
		.DEPTH (boel_pkg::CAPACITY)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_req.wr_en),
		.wr_addr (mem_req.wr_addr),
		.wr_data (mem_req.wr_data),
		.rd_en   (mem_req.rd_en),
		.rd_addr (mem_req.rd_addr),
		.rd_data (mem_rdata)
	);

endmodule

`default_nettype wire

// File: hw/rtl/boel_ram.sv
// boel_ram: generic simple dual-port ram, one write and one registered read port.
// No dependencies.
`default_nettype none

module boel_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/boel_ctrl.sv
// boel_ctrl: command sequencer of the ordered list engine; decodes a request,
// walks the entry memory to open or close a gap or to search, holds the result.
// Depends on boel_pkg and boel_if.
`default_nettype none

module boel_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	boel_req_if.sink                   req,
	boel_rsp_if.source                 rsp,
	output boel_pkg::mem_req_t         mem_req,
	input  wire logic [boel_pkg::DW-1:0] mem_rdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEC,
		ST_OPEN,
		ST_CLOSE,
		ST_SCAN,
		ST_RESP
	} state_t;

	state_t                          state_q;
	boel_pkg::cmd_t                  cmd_q;
	logic signed [boel_pkg::DW-1:0]  val_q;
	logic [boel_pkg::CMPW-1:0]       pos_q;
	logic [boel_pkg::CW-1:0]         pos_e_q;
	logic [boel_pkg::CW-1:0]         idx_q;
	logic [boel_pkg::CW-1:0]         total_q;
	logic                            fail_q;
	logic                            found_q;
	logic                            rd_vld_s1;
	logic [boel_pkg::AW-1:0]         wr_addr_s1;
	logic                            out_valid_q;
	logic                            out_status_q;
	logic                            out_found_q;
	logic signed [boel_pkg::DW-1:0]  out_fval_q;
	logic [boel_pkg::CNT_OW-1:0]     out_count_q;
	logic                            out_empty_q;

	logic                            full;
	logic                            empty;
	logic [boel_pkg::CMPW-1:0]       total_w;
	logic                            ins_pos_bad;
	logic                            rem_pos_bad;
	logic                            walk_done;
	logic [boel_pkg::AW-1:0]         sh_addr;
	logic                            rsp_free;

	assign full        = total_q == boel_pkg::CW'(boel_pkg::CAPACITY);
	assign empty       = total_q == '0;
	assign total_w     = boel_pkg::CMPW'(total_q);
	assign ins_pos_bad = empty ? (pos_q != '0) : (pos_q >= total_w);
	assign rem_pos_bad = pos_q >= total_w;
	assign walk_done   = !mem_req.rd_en && !rd_vld_s1;
	assign rsp_free    = !out_valid_q || rsp.ready;

	assign req.ready       = state_q == ST_IDLE;
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.found       = out_found_q;
	assign rsp.found_value = out_fval_q;
	assign rsp.entry_count = out_count_q;
	assign rsp.is_empty    = out_empty_q;

	// memory traffic: reads walk the list, writes replay delayed read data
	always_comb begin
		mem_req = '0;
		sh_addr = boel_pkg::AW'(idx_q);
		unique case (state_q)
			ST_OPEN: begin
				mem_req.rd_en   = idx_q > pos_e_q;
				mem_req.rd_addr = boel_pkg::AW'(idx_q - boel_pkg::CW'(1));
				sh_addr         = boel_pkg::AW'(idx_q);
				if (rd_vld_s1) begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = wr_addr_s1;
					mem_req.wr_data = mem_rdata;
				end else if (!mem_req.rd_en) begin
					// gap is open: drop the new value in
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = boel_pkg::AW'(pos_e_q);
					mem_req.wr_data = val_q;
				end
			end
			ST_CLOSE: begin
				mem_req.rd_en   = idx_q < total_q;
				mem_req.rd_addr = boel_pkg::AW'(idx_q);
				sh_addr         = boel_pkg::AW'(idx_q - boel_pkg::CW'(1));
				mem_req.wr_en   = rd_vld_s1;
				mem_req.wr_addr = wr_addr_s1;
				mem_req.wr_data = mem_rdata;
			end
			ST_SCAN: begin
				mem_req.rd_en   = idx_q < total_q;
				mem_req.rd_addr = boel_pkg::AW'(idx_q);
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	// sequencer, count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			total_q     <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1  <= mem_req.rd_en;
			wr_addr_s1 <= sh_addr;
			// result valid: load from the resp state, drop once taken
			if (state_q == ST_RESP && rsp_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						cmd_q   <= boel_pkg::cmd_t'(req.cmd);
						val_q   <= req.item_value;
						pos_q   <= boel_pkg::CMPW'(req.position);
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					found_q <= 1'b0;
					unique case (cmd_q)
						boel_pkg::CMD_INS_HEAD: begin
							pos_e_q <= '0;
							idx_q   <= total_q;
							fail_q  <= full;
							state_q <= full ? ST_RESP : ST_OPEN;
						end
						boel_pkg::CMD_INS_TAIL: begin
							pos_e_q <= total_q;
							idx_q   <= total_q;
							fail_q  <= full;
							state_q <= full ? ST_RESP : ST_OPEN;
						end
						boel_pkg::CMD_INS_POS: begin
							pos_e_q <= boel_pkg::CW'(pos_q);
							idx_q   <= total_q;
							fail_q  <= full || ins_pos_bad;
							state_q <= (full || ins_pos_bad) ? ST_RESP : ST_OPEN;
						end
						boel_pkg::CMD_REM_HEAD: begin
							idx_q   <= boel_pkg::CW'(1);
							fail_q  <= empty;
							state_q <= empty ? ST_RESP : ST_CLOSE;
						end
						boel_pkg::CMD_REM_TAIL: begin
							// nothing to shift, the count just drops
							idx_q   <= total_q;
							fail_q  <= empty;
							state_q <= empty ? ST_RESP : ST_CLOSE;
						end
						boel_pkg::CMD_REM_POS: begin
							idx_q   <= boel_pkg::CW'(pos_q) + boel_pkg::CW'(1);
							fail_q  <= rem_pos_bad;
							state_q <= rem_pos_bad ? ST_RESP : ST_CLOSE;
						end
						boel_pkg::CMD_SEARCH: begin
							idx_q   <= '0;
							fail_q  <= 1'b0;
							state_q <= ST_SCAN;
						end
						boel_pkg::CMD_CLEAR: begin
							total_q <= '0;
							fail_q  <= 1'b0;
							state_q <= ST_RESP;
						end
						default: begin
							fail_q  <= 1'b0;
							state_q <= ST_RESP;
						end
					endcase
				end
				ST_OPEN: begin
					if (mem_req.rd_en) begin
						idx_q <= idx_q - boel_pkg::CW'(1);
					end
					if (walk_done) begin
						total_q <= total_q + boel_pkg::CW'(1);
						state_q <= ST_RESP;
					end
				end
				ST_CLOSE: begin
					if (mem_req.rd_en) begin
						idx_q <= idx_q + boel_pkg::CW'(1);
					end
					if (walk_done) begin
						total_q <= total_q - boel_pkg::CW'(1);
						state_q <= ST_RESP;
					end
				end
				ST_SCAN: begin
					if (mem_req.rd_en) begin
						idx_q <= idx_q + boel_pkg::CW'(1);
					end
					if (rd_vld_s1 && (mem_rdata == val_q)) begin
						found_q <= 1'b1;
					end
					if (walk_done) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (rsp_free) begin
						out_status_q <= fail_q;
						out_found_q  <= found_q;
						out_fval_q   <= found_q ? val_q : '0;
						out_count_q  <= boel_pkg::CNT_OW'(total_q);
						out_empty_q  <= empty;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a shift never reads the entry it writes in the same cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.rd_en && mem_req.wr_en |-> mem_req.rd_addr != mem_req.wr_addr)
		else $error("read and write hit the same entry");

	// count never exceeds capacity
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= boel_pkg::CW'(boel_pkg::CAPACITY))
		else $error("entry count above capacity");

	// a search never modifies the store
	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> !mem_req.wr_en)
		else $error("write during search");

	// an accepted request is decoded in the next cycle
	a_accept_dec: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q == ST_DEC)
		else $error("accepted request not decoded");

	// a result is loaded only into a free output register
	a_rsp_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RESP && out_valid_q && !rsp.ready |=> state_q == ST_RESP)
		else $error("result overwrote a pending one");

endmodule

`default_nettype wire

// File: verif/boel_list_scoreboard_pkg.sv
// scoreboard for the ordered list engine: a shadow copy of the list that
// predicts each result and checks results in order
// depends on boel_pkg for sizes and command codes
`timescale 1ns / 1ps

package boel_list_scoreboard_pkg;

	import boel_pkg::*;

	// one result as the engine reports it
	typedef struct packed {
		logic                 status;
		logic                 found;
		logic signed [DW-1:0] found_value;
		logic [CNT_OW-1:0]    entry_count;
		logic                 is_empty;
	} list_result_t;

	class ListScoreboard;

		// shadow list, head at index 0
		logic signed [DW-1:0] entries [CAPACITY];
		int unsigned fill;
		list_result_t expected_q [$];

		// run statistics
		int unsigned mismatches;
		int unsigned results_seen;
		int unsigned refusals;
		int unsigned search_hits;
		int unsigned peak_fill;
		int unsigned cmd_seen [8];

		function new();
			fill = 0;
			mismatches = 0;
			results_seen = 0;
			refusals = 0;
			search_hits = 0;
			peak_fill = 0;
			foreach (cmd_seen[k]) cmd_seen[k] = 0;
		endfunction

		// shift entries from index at onward up by one
		function void open_slot(int unsigned at);
			int unsigned i;
			for (i = fill; i > at; i--) entries[i] = entries[i - 1];
		endfunction

		// drop entry at, shifting the rest down
		function void close_slot(int unsigned at);
			int unsigned i;
			for (i = at; i + 1 < fill; i++) entries[i] = entries[i + 1];
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// apply one accepted request to the shadow list and queue its result
		function void note_request(cmd_t op, logic signed [DW-1:0] val,
				logic [POS_W-1:0] pos);
			list_result_t r;
			int unsigned i;
			r = '0;
			cmd_seen[op]++;
			case (op)
				CMD_INS_HEAD: begin
					if (fill >= CAPACITY) begin
						r.status = 1'b1;
					end else begin
						open_slot(0);
						entries[0] = val;
						fill++;
					end
				end
				CMD_INS_TAIL: begin
					if (fill >= CAPACITY) begin
						r.status = 1'b1;
					end else begin
						entries[fill] = val;
						fill++;
					end
				end
				CMD_INS_POS: begin
					// position 0 is allowed into an empty list, append is not
					if (fill >= CAPACITY || (fill == 0 ? pos != 0 : pos >= fill)) begin
						r.status = 1'b1;
					end else begin
						open_slot(pos);
						entries[pos] = val;
						fill++;
					end
				end
				CMD_REM_HEAD: begin
					if (fill == 0) begin
						r.status = 1'b1;
					end else begin
						close_slot(0);
						fill--;
					end
				end
				CMD_REM_TAIL: begin
					if (fill == 0) r.status = 1'b1;
					else fill--;
				end
				CMD_REM_POS: begin
					if (pos >= fill) begin
						r.status = 1'b1;
					end else begin
						close_slot(pos);
						fill--;
					end
				end
				CMD_SEARCH: begin
					// first match from the head
					for (i = 0; i < fill && !r.found; i++) begin
						if (entries[i] == val) begin
							r.found = 1'b1;
							r.found_value = val;
						end
					end
					if (r.found) search_hits++;
				end
				default: begin
					fill = 0;
				end
			endcase
			if (r.status) refusals++;
			if (fill > peak_fill) peak_fill = fill;
			r.entry_count = CNT_OW'(fill);
			r.is_empty = (fill == 0);
			expected_q.push_back(r);
		endfunction

		// compare one accepted result with the oldest prediction
		function void check_result(list_result_t got);
			list_result_t want;
			results_seen++;
			if (expected_q.size() == 0) begin
				$error("unexpected result with no request pending");
				mismatches++;
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				mismatches++;
			end
			if (got.found !== want.found) begin
				$error("found: expected %0d, actual %0d", want.found, got.found);
				mismatches++;
			end
			if (got.found_value !== want.found_value) begin
				$error("found_value: expected %0d, actual %0d",
					want.found_value, got.found_value);
				mismatches++;
			end
			if (got.entry_count !== want.entry_count) begin
				$error("entry_count: expected %0d, actual %0d",
					want.entry_count, got.entry_count);
				mismatches++;
			end
			if (got.is_empty !== want.is_empty) begin
				$error("is_empty: expected %0d, actual %0d", want.is_empty, got.is_empty);
				mismatches++;
			end
		endfunction

	endclass

endpackage

// File: verif/bounded_ordered_list_engine_core_test.sv
// top-level testbench of the ordered list engine: directed corner requests,
// then random fill and drain traffic with bursty requests and stalled results
// depends on boel_pkg, boel_if and boel_list_scoreboard_pkg
`timescale 1ns / 1ps

module bounded_ordered_list_engine_core_test;

	import boel_pkg::*;
	import boel_list_scoreboard_pkg::*;

	localparam int N_RANDOM     = 1850;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = CAPACITY + 16;

	typedef enum {PHASE_GROW, PHASE_SHRINK, PHASE_MIXED} list_phase_t;
	typedef enum {SINK_OPEN, SINK_COIN, SINK_LONG_STALL, SINK_MOSTLY} sink_mode_t;

	logic clk;
	logic arst_n;
	int unsigned cycles;
	int unsigned burst_left;
	int unsigned phase_left;
	list_phase_t phase;

	boel_req_if req_ch ();
	boel_rsp_if rsp_ch ();

	ListScoreboard list_sb = new();

	bounded_ordered_list_engine_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watch both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				list_sb.note_request(cmd_t'(req_ch.cmd), req_ch.item_value, req_ch.position);
			if (rsp_ch.valid && rsp_ch.ready)
				list_sb.check_result({rsp_ch.status, rsp_ch.found, rsp_ch.found_value,
					rsp_ch.entry_count, rsp_ch.is_empty});
		end
	end

	// result side back-pressure, switching between stall modes
	initial begin : result_sink
		sink_mode_t mode;
		int unsigned mode_left;
		int unsigned stall_left;
		rsp_ch.ready = 1'b0;
		mode = SINK_OPEN;
		mode_left = 0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode = sink_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(50, 400);
			end
			mode_left--;
			case (mode)
				SINK_OPEN: rsp_ch.ready = 1'b1;
				SINK_COIN: rsp_ch.ready = 1'($urandom_range(0, 1));
				SINK_LONG_STALL: begin
					if (stall_left > 0) begin
						stall_left--;
						rsp_ch.ready = 1'b0;
					end else begin
						rsp_ch.ready = 1'b1;
						if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 20);
					end
				end
				default: rsp_ch.ready = ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// timeout
	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("end of test: mismatches");
		$finish;
	end

	// drive one request from a falling edge; returns at the falling edge
	// after acceptance with valid still high
	task automatic send_request(input cmd_t op, input logic signed [DW-1:0] val,
			input logic [POS_W-1:0] pos);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 60);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req_ch.valid = 1'b1;
		req_ch.cmd = op;
		req_ch.item_value = val;
		req_ch.position = pos;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	// hold requests until every result is back
	task automatic wait_list_idle();
		req_ch.valid = 1'b0;
		while (list_sb.pending() != 0) @(negedge clk);
	endtask

	// one random request, steered by the current fill phase
	task automatic send_random_request();
		cmd_t op;
		logic signed [DW-1:0] val;
		logic [POS_W-1:0] pos;
		int unsigned fill;
		int unsigned roll;
		int unsigned ins_w;
		fill = list_sb.fill;
		if (phase_left == 0) begin
			phase = list_phase_t'($urandom_range(0, 2));
			phase_left = $urandom_range(60, 200);
		end
		phase_left--;
		case (phase)
			PHASE_GROW: ins_w = 70;
			PHASE_SHRINK: ins_w = 20;
			default: ins_w = 45;
		endcase

		// pick the command
		roll = $urandom_range(0, 99);
		if (phase != PHASE_GROW && $urandom_range(0, 199) == 0)
			op = CMD_CLEAR;
		else if (roll < ins_w)
			op = cmd_t'($urandom_range(CMD_INS_HEAD, CMD_INS_POS));
		else if (roll < 88)
			op = cmd_t'($urandom_range(CMD_REM_HEAD, CMD_REM_POS));
		else
			op = CMD_SEARCH;

		// pick the value: full range, a small pool for duplicates, or extremes
		case ($urandom_range(0, 9))
			0, 1: val = $urandom_range(0, 7);
			2: begin
				case ($urandom_range(0, 3))
					0: val = 32'sh8000_0000;
					1: val = 32'sh7fff_ffff;
					2: val = '0;
					default: val = '1;
				endcase
			end
			default: val = $urandom;
		endcase
		if (op == CMD_SEARCH && fill > 0 && $urandom_range(0, 9) < 6)
			val = list_sb.entries[$urandom_range(0, fill - 1)];

		// pick the position: mostly in range, sometimes at the count or anywhere
		roll = $urandom_range(0, 9);
		if (roll == 0)
			pos = POS_W'($urandom_range(0, CAPACITY - 1));
		else if (roll == 1)
			pos = POS_W'(fill);
		else if (fill == 0)
			pos = '0;
		else
			pos = POS_W'($urandom_range(0, fill - 1));

		send_request(op, val, pos);
	endtask

	// main sequence
	initial begin : stimulus
		int unsigned n;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_INS_HEAD;
		req_ch.item_value = '0;
		req_ch.position = '0;
		burst_left = 0;
		phase_left = 0;
		phase = PHASE_GROW;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// removals and search on an empty list, positional insert edge cases
		send_request(CMD_REM_HEAD, 32'sd11, 6'd0);
		send_request(CMD_REM_TAIL, 32'sd12, 6'd0);
		send_request(CMD_REM_POS, 32'sd13, 6'd0);
		send_request(CMD_SEARCH, 32'sd0, 6'd0);
		send_request(CMD_INS_POS, 32'sd7, 6'd1);
		send_request(CMD_INS_POS, 32'sh8000_0000, 6'd0);
		send_request(CMD_INS_HEAD, 32'sh7fff_ffff, 6'd63);
		send_request(CMD_INS_TAIL, -32'sd1, 6'd0);
		send_request(CMD_INS_POS, 32'sd99, 6'd3);
		send_request(CMD_INS_POS, 32'sd0, 6'd2);
		// search hits, a miss, and a hit on zero
		send_request(CMD_SEARCH, -32'sd1, 6'd0);
		send_request(CMD_SEARCH, 32'sd12345, 6'd0);
		send_request(CMD_SEARCH, 32'sd0, 6'd0);
		send_request(CMD_SEARCH, 32'sh8000_0000, 6'd0);
		// positional remove at and below the count, then both ends
		send_request(CMD_REM_POS, 32'sd0, 6'd4);
		send_request(CMD_REM_POS, 32'sd0, 6'd1);
		send_request(CMD_REM_TAIL, 32'sd0, 6'd0);
		send_request(CMD_REM_HEAD, 32'sd0, 6'd0);
		// duplicates, clear, clear on empty
		send_request(CMD_INS_TAIL, 32'sd5, 6'd0);
		send_request(CMD_INS_TAIL, 32'sd5, 6'd0);
		send_request(CMD_SEARCH, 32'sd5, 6'd0);
		send_request(CMD_CLEAR, 32'sd0, 6'd0);
		send_request(CMD_CLEAR, 32'sd0, 6'd0);
		send_request(CMD_INS_POS, 32'sd1, 6'd63);
		wait_list_idle();

		// random traffic, with one more full pause half way
		for (n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 2) wait_list_idle();
			send_random_request();
		end
		wait_list_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("requests: ins head/tail/pos %0d/%0d/%0d, rem head/tail/pos %0d/%0d/%0d",
			list_sb.cmd_seen[CMD_INS_HEAD], list_sb.cmd_seen[CMD_INS_TAIL],
			list_sb.cmd_seen[CMD_INS_POS], list_sb.cmd_seen[CMD_REM_HEAD],
			list_sb.cmd_seen[CMD_REM_TAIL], list_sb.cmd_seen[CMD_REM_POS]);
		$display("search %0d (%0d hits), clear %0d, refused %0d, peak fill %0d, results %0d",
			list_sb.cmd_seen[CMD_SEARCH], list_sb.search_hits, list_sb.cmd_seen[CMD_CLEAR],
			list_sb.refusals, list_sb.peak_fill, list_sb.results_seen);
		if (list_sb.mismatches == 0 && list_sb.pending() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/boel_pkg.sv
hw/rtl/boel_if.sv
hw/rtl/boel_ram.sv
hw/rtl/boel_ctrl.sv
hw/rtl/bounded_ordered_list_engine_core.sv
verif/boel_list_scoreboard_pkg.sv
verif/bounded_ordered_list_engine_core_test.sv
